@@ hw/rtl/nch_pkg.sv @@
package nch_pkg;

  localparam int ELEMS  = 9;
  localparam int ELEM_W = 12;
  localparam int PIX_W  = 8;
  localparam int SQ_W   = 24;
  localparam int DIST_W = 28;
  localparam int CFG_W  = 11;
  localparam int CMD_W  = 2;

  localparam logic [CFG_W-1:0] CLUSTERS_RESET = 11'd1000;

  localparam logic [CMD_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [CMD_W-1:0] OP_READ     = 2'd2;
  localparam logic [CMD_W-1:0] OP_CLEAR    = 2'd3;

  typedef struct packed {
    logic accept;
    logic sweep_wr;
    logic search_issue;
    logic hist_rd_idx;
    logic hist_rd_best;
    logic hist_upd;
    logic cnt_capture;
    logic out_load;
  } nch_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic search_last;
    logic pipe_busy;
    logic out_busy;
    logic in_range;
  } nch_stat_t;

endpackage

@@ hw/rtl/nearest_centroid_histogram_top.sv @@
// One item is in work at a time; the next is taken the cycle after its result enters
// the output register. A classify reads one centroid from the RAM per cycle.
// Reset: synchronous; afterwards a pass over all MAX_CLUSTERS entries zeroes the
// histogram RAM with in_ready low. Configuration writes are taken throughout.
module nearest_centroid_histogram_top
  import nch_pkg::*;
#(
  parameter int MAX_CLUSTERS = 1024,
  parameter int COUNT_BITS   = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [CFG_W-1:0]                cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [CMD_W-1:0]                cmd,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] entry_index,
  input  logic [ELEM_W-1:0]               elem0,
  input  logic [ELEM_W-1:0]               elem1,
  input  logic [ELEM_W-1:0]               elem2,
  input  logic [ELEM_W-1:0]               elem3,
  input  logic [ELEM_W-1:0]               elem4,
  input  logic [ELEM_W-1:0]               elem5,
  input  logic [ELEM_W-1:0]               elem6,
  input  logic [ELEM_W-1:0]               elem7,
  input  logic [ELEM_W-1:0]               elem8,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [$clog2(MAX_CLUSTERS)-1:0] nearest_index,
  output logic [DIST_W-1:0]               best_distance,
  output logic [COUNT_BITS-1:0]           bin_count,
  output logic                            status
);

  nch_cmd_t  ctl;
  nch_stat_t stat;

  nch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  nch_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .entry_index   (entry_index),
    .elems         ({elem8, elem7, elem6, elem5, elem4, elem3, elem2, elem1, elem0}),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .nearest_index (nearest_index),
    .best_distance (best_distance),
    .bin_count     (bin_count),
    .status        (status)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.out_load))
    else $error("output beat raised without a result load");

  a_err_no_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && (best_distance != '0)))
    else $error("error status with a nonzero distance");

  a_hist_excl: assert property (@(posedge clk) disable iff (rst)
    ctl.hist_upd |-> !(ctl.sweep_wr || ctl.search_issue || stat.pipe_busy))
    else $error("count update overlaps sweep or search");

endmodule

@@ hw/rtl/nch_ram.sv @@
module nch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/nch_ctrl.sv @@
module nch_ctrl
  import nch_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] cmd,
  input  nch_stat_t        stat,
  output logic             in_ready,
  output nch_cmd_t         ctl
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_CLEAR  = 8'b00000100,
    S_SEARCH = 8'b00001000,
    S_DRAIN  = 8'b00010000,
    S_RDCNT  = 8'b00100000,
    S_UPD    = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          unique case (cmd)
            OP_LOAD:     state_next = S_DONE;
            OP_CLASSIFY: state_next = S_SEARCH;
            OP_READ: begin
              if (stat.in_range) begin
                ctl.hist_rd_idx = 1'b1;
                state_next = S_RDCNT;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_CLEAR:    state_next = S_CLEAR;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_SEARCH: begin
        ctl.search_issue = 1'b1;
        if (stat.search_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // wait until the last distance has been compared
        if (!stat.pipe_busy) begin
          ctl.hist_rd_best = 1'b1;
          state_next = S_UPD;
        end
      end
      S_RDCNT: begin
        ctl.cnt_capture = 1'b1;
        state_next = S_DONE;
      end
      S_UPD: begin
        ctl.hist_upd = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/nch_datapath.sv @@
module nch_datapath
  import nch_pkg::*;
#(
  parameter int MAX_CLUSTERS = 1024,
  parameter int COUNT_BITS   = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nch_cmd_t                        ctl,
  output nch_stat_t                       stat,
  input  logic                            cfg_we,
  input  logic [CFG_W-1:0]                cfg_wdata,
  input  logic [CMD_W-1:0]                cmd,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] entry_index,
  input  logic [ELEMS*ELEM_W-1:0]         elems,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [$clog2(MAX_CLUSTERS)-1:0] nearest_index,
  output logic [DIST_W-1:0]               best_distance,
  output logic [COUNT_BITS-1:0]           bin_count,
  output logic                            status
);

  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int WIDE_W = IDX_W + 2;
  localparam logic [WIDE_W-1:0] MAX_W = WIDE_W'(MAX_CLUSTERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLUSTERS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [CFG_W-1:0]  clusters_in_use;
  logic [WIDE_W-1:0] cfg_wide;
  logic [IDX_W-1:0]  n_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= CLUSTERS_RESET;
    end else if (cfg_we) begin
      clusters_in_use <= cfg_wdata;
    end
  end

  // clamp the register to 1..MAX_CLUSTERS, kept as the last searched index
  always_comb begin
    cfg_wide = WIDE_W'(clusters_in_use);
    if (cfg_wide == '0) begin
      n_m1 = '0;
    end else if (cfg_wide > MAX_W) begin
      n_m1 = LAST_IDX;
    end else begin
      n_m1 = IDX_W'(cfg_wide - WIDE_W'(1));
    end
  end

  assign stat.in_range = (entry_index <= n_m1);

  // shared sweep and search counter, always back at zero when idle
  logic [IDX_W-1:0] scan;
  assign stat.sweep_last  = (scan == LAST_IDX);
  assign stat.search_last = (scan == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (ctl.sweep_wr) begin
      scan <= stat.sweep_last ? '0 : scan + IDX_W'(1);
    end else if (ctl.search_issue) begin
      scan <= stat.search_last ? '0 : scan + IDX_W'(1);
    end
  end

  // captured patch, saturated and taken to 8.4
  logic [ELEM_W-1:0] px [ELEMS];

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      for (int k = 0; k < ELEMS; k++) begin
        if (elems[k*ELEM_W +: ELEM_W] > ELEM_W'(255)) begin
          px[k] <= {8'hFF, 4'h0};
        end else begin
          px[k] <= {elems[k*ELEM_W +: PIX_W], 4'h0};
        end
      end
    end
  end

  logic [ELEMS*ELEM_W-1:0] cent_rd;

  nch_ram #(.WIDTH(ELEMS*ELEM_W), .DEPTH(MAX_CLUSTERS)) u_cent_ram (
    .clk   (clk),
    .we    (ctl.accept && (cmd == OP_LOAD) && stat.in_range),
    .waddr (entry_index),
    .wdata (elems),
    .raddr (scan),
    .rdata (cent_rd)
  );

  // distance pipeline: RAM data, squares, sum, compare
  logic              va, vb, vc;
  logic [IDX_W-1:0]  ia, ib, ic;
  logic [SQ_W-1:0]   sq [ELEMS];
  logic [DIST_W-1:0] sum;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0]  best_j;
  logic [DIST_W-1:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < ELEMS; k++) begin
      sum_next = sum_next + DIST_W'(sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= ctl.search_issue;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    logic [ELEM_W-1:0] c;
    logic [ELEM_W-1:0] d;
    ia <= scan;
    ib <= ia;
    ic <= ib;
    for (int k = 0; k < ELEMS; k++) begin
      c = cent_rd[k*ELEM_W +: ELEM_W];
      d = (px[k] >= c) ? px[k] - c : c - px[k];
      sq[k] <= d * d;
    end
    sum <= sum_next;
    // later index wins on a tie; index zero always seeds the search
    if (vc && ((ic == '0) || (sum <= best))) begin
      best   <= sum;
      best_j <= ic;
    end
  end

  assign stat.pipe_busy = va | vb | vc;

  logic [COUNT_BITS-1:0] hist_rd;
  logic [COUNT_BITS-1:0] hist_inc;
  logic [IDX_W-1:0]      hist_ra;

  assign hist_ra  = ctl.hist_rd_best ? best_j : entry_index;
  assign hist_inc = (hist_rd == COUNT_MAX) ? hist_rd : hist_rd + COUNT_BITS'(1);

  nch_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLUSTERS)) u_hist_ram (
    .clk   (clk),
    .we    (ctl.sweep_wr || ctl.hist_upd),
    .waddr (ctl.sweep_wr ? scan : best_j),
    .wdata (ctl.sweep_wr ? '0 : hist_inc),
    .raddr (hist_ra),
    .rdata (hist_rd)
  );

  // pending result
  logic [IDX_W-1:0]      res_index;
  logic [DIST_W-1:0]     res_dist;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_status;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res_index  <= entry_index;
      res_dist   <= '0;
      res_count  <= '0;
      res_status <= ((cmd == OP_LOAD) || (cmd == OP_READ)) && !stat.in_range;
    end else if (ctl.hist_upd) begin
      res_index <= best_j;
      res_dist  <= best;
      res_count <= hist_inc;
    end else if (ctl.cnt_capture) begin
      res_count <= hist_rd;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      nearest_index <= res_index;
      best_distance <= res_dist;
      bin_count     <= res_count;
      status        <= res_status;
    end
  end

endmodule
